FILE: src/owtr_pkg.sv
// ----------------------------------------------------------------------------
// owtr_pkg
// Shared types, register codes and command bytes of the one-wire reader.
// ----------------------------------------------------------------------------
package owtr_pkg;

    localparam int CFG_W  = 10;
    localparam int TEMP_W = 16;

    // Register indexes of the configuration port
    typedef enum logic [2:0] {
        REG_RESET_LOW     = 3'd0,
        REG_PRESENCE_WAIT = 3'd1,
        REG_SHORT_SLOT    = 3'd2,
        REG_LONG_SLOT     = 3'd3,
        REG_READ_LOW      = 3'd4,
        REG_READ_SAMPLE   = 3'd5,
        REG_READ_RECOVERY = 3'd6,
        REG_COMMAND_GAP   = 3'd7
    } t_reg_idx;

    localparam logic [CFG_W-1:0] RST_RESET_LOW     = 10'd500;
    localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT = 10'd60;
    localparam logic [CFG_W-1:0] RST_SHORT_SLOT    = 10'd10;
    localparam logic [CFG_W-1:0] RST_LONG_SLOT     = 10'd70;
    localparam logic [CFG_W-1:0] RST_READ_LOW      = 10'd1;
    localparam logic [CFG_W-1:0] RST_READ_SAMPLE   = 10'd10;
    localparam logic [CFG_W-1:0] RST_READ_RECOVERY = 10'd50;
    localparam logic [CFG_W-1:0] RST_COMMAND_GAP   = 10'd100;

    // Bus commands
    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low;
        logic [CFG_W-1:0] presence_wait;
        logic [CFG_W-1:0] short_slot;
        logic [CFG_W-1:0] long_slot;
        logic [CFG_W-1:0] read_low;
        logic [CFG_W-1:0] read_sample;
        logic [CFG_W-1:0] read_recovery;
        logic [CFG_W-1:0] command_gap;
    } t_cfg;

    typedef struct packed {
        logic signed [TEMP_W-1:0] temperature;
        logic                     no_device;
        logic                     done;
        logic                     busy;
        logic                     drive_low;
    } t_result;

endpackage

FILE: src/owtr_cfg_regs.sv
// ----------------------------------------------------------------------------
// owtr_cfg_regs
// Timing register file, written through the plain write port.
// ----------------------------------------------------------------------------
module owtr_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_index,
    input  logic [owtr_pkg::CFG_W-1:0] i_cfg_wdata,
    output owtr_pkg::t_cfg             o_cfg
);

    owtr_pkg::t_cfg r_cfg;
    owtr_pkg::t_reg_idx w_idx;

    assign w_idx = owtr_pkg::t_reg_idx'(i_cfg_index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low     <= owtr_pkg::RST_RESET_LOW;
            r_cfg.presence_wait <= owtr_pkg::RST_PRESENCE_WAIT;
            r_cfg.short_slot    <= owtr_pkg::RST_SHORT_SLOT;
            r_cfg.long_slot     <= owtr_pkg::RST_LONG_SLOT;
            r_cfg.read_low      <= owtr_pkg::RST_READ_LOW;
            r_cfg.read_sample   <= owtr_pkg::RST_READ_SAMPLE;
            r_cfg.read_recovery <= owtr_pkg::RST_READ_RECOVERY;
            r_cfg.command_gap   <= owtr_pkg::RST_COMMAND_GAP;
        end else if (i_cfg_we) begin
            case (w_idx)
                owtr_pkg::REG_RESET_LOW:     r_cfg.reset_low     <= i_cfg_wdata;
                owtr_pkg::REG_PRESENCE_WAIT: r_cfg.presence_wait <= i_cfg_wdata;
                owtr_pkg::REG_SHORT_SLOT:    r_cfg.short_slot    <= i_cfg_wdata;
                owtr_pkg::REG_LONG_SLOT:     r_cfg.long_slot     <= i_cfg_wdata;
                owtr_pkg::REG_READ_LOW:      r_cfg.read_low      <= i_cfg_wdata;
                owtr_pkg::REG_READ_SAMPLE:   r_cfg.read_sample   <= i_cfg_wdata;
                owtr_pkg::REG_READ_RECOVERY: r_cfg.read_recovery <= i_cfg_wdata;
                owtr_pkg::REG_COMMAND_GAP:   r_cfg.command_gap   <= i_cfg_wdata;
                default:                     r_cfg               <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/owtr_seq.sv
// ----------------------------------------------------------------------------
// owtr_seq
// Bus sequencer: phase, tick timer, bit and byte counters, shift register and
// temperature store. Advances one tick per fire.
// ----------------------------------------------------------------------------
module owtr_seq #(
    parameter int TIMER_BITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_start,
    input  logic              i_bus,
    input  owtr_pkg::t_cfg    i_cfg,
    output owtr_pkg::t_result o_res
);

    localparam int CMP_W = ((TIMER_BITS > owtr_pkg::CFG_W) ? TIMER_BITS : owtr_pkg::CFG_W) + 1;

    localparam logic [2:0] STEP_SKIP1    = 3'd0;
    localparam logic [2:0] STEP_CONVERT  = 3'd1;
    localparam logic [2:0] STEP_RESET2   = 3'd2;
    localparam logic [2:0] STEP_READ_CMD = 3'd3;
    localparam logic [2:0] STEP_LSB      = 3'd4;
    localparam logic [2:0] STEP_MSB      = 3'd5;
    localparam logic [2:0] STEP_CLOSE    = 3'd6;

    typedef enum logic [3:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_GAP, PH_WR_LOW, PH_WR_HIGH,
        PH_RD_LOW, PH_RD_WAIT, PH_RD_REC
    } t_phase;

    t_phase                    r_phase, n_phase;
    logic [TIMER_BITS-1:0]     r_tick,  n_tick;
    logic [2:0]                r_bit,   n_bit;
    logic [2:0]                r_step,  n_step;
    logic [7:0]                r_shift, n_shift;
    logic [7:0]                r_low,   n_low;
    logic [owtr_pkg::TEMP_W-1:0] r_temp, n_temp;

    logic [owtr_pkg::CFG_W-1:0] w_len;
    logic [CMP_W-1:0]           w_len_ext;
    logic [CMP_W-1:0]           w_tick_p1;
    logic                       w_last;
    logic                       w_begin;
    logic                       w_done;
    logic                       w_nodev;

    function automatic logic [7:0] command_for(input logic [2:0] step);
        logic [7:0] cmd;
        if (step == STEP_CONVERT) begin
            cmd = owtr_pkg::CMD_CONVERT;
        end else if (step == STEP_READ_CMD) begin
            cmd = owtr_pkg::CMD_READ_SCRATCH;
        end else begin
            cmd = owtr_pkg::CMD_SKIP_ROM;
        end
        return cmd;
    endfunction

    // Select the length of the running phase
    always_comb begin
        case (r_phase)
            PH_RST_LOW:  w_len = i_cfg.reset_low;
            PH_RST_WAIT: w_len = i_cfg.presence_wait;
            PH_GAP:      w_len = i_cfg.command_gap;
            PH_WR_LOW:   w_len = r_shift[0] ? i_cfg.short_slot : i_cfg.long_slot;
            PH_WR_HIGH:  w_len = r_shift[0] ? i_cfg.long_slot : i_cfg.short_slot;
            PH_RD_LOW:   w_len = i_cfg.read_low;
            PH_RD_WAIT:  w_len = i_cfg.read_sample;
            PH_RD_REC:   w_len = i_cfg.read_recovery;
            default:     w_len = owtr_pkg::CFG_W'(1);
        endcase
        if (w_len == '0) begin
            w_len = owtr_pkg::CFG_W'(1);
        end
    end

    assign w_len_ext = CMP_W'(w_len);
    assign w_tick_p1 = CMP_W'(r_tick) + CMP_W'(1);
    assign w_last    = (w_tick_p1 >= w_len_ext) || (r_tick == '1);

    always_comb begin
        n_phase = r_phase;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_step  = r_step;
        n_shift = r_shift;
        n_low   = r_low;
        n_temp  = r_temp;
        w_begin = 1'b0;
        w_done  = 1'b0;
        w_nodev = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (i_start) begin
                n_phase = PH_RST_LOW;
                n_tick  = '0;
                n_bit   = '0;
                n_step  = STEP_SKIP1;
            end
        end else if (!w_last) begin
            n_tick = r_tick + TIMER_BITS'(1);
        end else begin
            n_tick = '0;
            case (r_phase)
                PH_RST_LOW: begin
                    n_phase = PH_RST_WAIT;
                end
                PH_RST_WAIT: begin
                    if (r_step == STEP_CLOSE) begin
                        // closing reset: presence sample ignored
                        n_phase = PH_IDLE;
                        w_done  = 1'b1;
                    end else if (!i_bus) begin
                        n_phase = PH_GAP;
                    end else begin
                        n_phase = PH_IDLE;
                        w_done  = 1'b1;
                        w_nodev = 1'b1;
                    end
                end
                PH_GAP: begin
                    n_shift = command_for(r_step);
                    n_bit   = '0;
                    n_phase = PH_WR_LOW;
                end
                PH_WR_LOW: begin
                    n_phase = PH_WR_HIGH;
                end
                PH_WR_HIGH: begin
                    n_shift = r_shift >> 1;
                    n_bit   = r_bit + 3'd1;
                    if (n_bit == '0) begin
                        n_step  = r_step + 3'd1;
                        w_begin = 1'b1;
                    end else begin
                        n_phase = PH_WR_LOW;
                    end
                end
                PH_RD_LOW: begin
                    n_phase = PH_RD_WAIT;
                end
                PH_RD_WAIT: begin
                    n_shift = {i_bus, r_shift[7:1]};
                    n_phase = PH_RD_REC;
                end
                PH_RD_REC: begin
                    n_bit = r_bit + 3'd1;
                    if (n_bit == '0) begin
                        if (r_step == STEP_LSB) begin
                            n_low = r_shift;
                        end else begin
                            n_temp = {r_shift, r_low};
                        end
                        n_step  = r_step + 3'd1;
                        w_begin = 1'b1;
                    end else begin
                        n_phase = PH_RD_LOW;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        // Open the next byte step
        if (w_begin) begin
            n_bit = '0;
            case (n_step) inside
                STEP_CONVERT, STEP_READ_CMD: begin
                    n_shift = command_for(n_step);
                    n_phase = PH_WR_LOW;
                end
                STEP_LSB, STEP_MSB: begin
                    n_shift = '0;
                    n_phase = PH_RD_LOW;
                end
                STEP_RESET2: begin
                    n_phase = PH_RST_LOW;
                end
                default: begin
                    n_step  = STEP_CLOSE;
                    n_phase = PH_RST_LOW;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_tick  <= '0;
            r_bit   <= '0;
            r_step  <= '0;
            r_shift <= '0;
            r_low   <= '0;
            r_temp  <= '0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_tick  <= n_tick;
            r_bit   <= n_bit;
            r_step  <= n_step;
            r_shift <= n_shift;
            r_low   <= n_low;
            r_temp  <= n_temp;
        end
    end

    assign o_res.drive_low   = (r_phase inside {PH_RST_LOW, PH_WR_LOW, PH_RD_LOW});
    assign o_res.busy        = (r_phase != PH_IDLE);
    assign o_res.done        = w_done;
    assign o_res.no_device   = w_nodev;
    assign o_res.temperature = n_temp;

endmodule

FILE: src/one_wire_temperature_reader_core.sv
// ----------------------------------------------------------------------------
// one_wire_temperature_reader_core
// One-wire bus master that reads one temperature sensor, one item per tick.
// ----------------------------------------------------------------------------
// Pipeline: a tick item is held in the input register, then the sequencer
//   step stores its result item in the result register.
// Throughput: one item per cycle unless the output side stalls; the result register
//   frees the input side whenever the output side takes its item in the same cycle.
// Reset: synchronous, active low; clears the sequencer to idle, the timing
//   registers to their defaults and both stage valid flags.
module one_wire_temperature_reader_core #(
    parameter int TIMER_BITS = 10
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Tick stream in
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [7:0]                 i_s_tdata,   // [0] start_request, [1] bus_level
    // Result stream out
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [23:0]                o_m_tdata,   // [0] drive_low, [1] busy_res,
                                                    // [2] done_res, [3] no_device,
                                                    // [19:4] temperature
    // Configuration write port
    input  logic                       i_cfg_we,
    input  logic [2:0]                 i_cfg_index,
    input  logic [owtr_pkg::CFG_W-1:0] i_cfg_wdata
);

    logic              r_in_valid;
    logic              r_in_start;
    logic              r_in_bus;
    logic              r_out_valid;
    owtr_pkg::t_result r_out;

    logic              w_out_free;
    logic              w_fire;
    logic              w_in_take;
    owtr_pkg::t_cfg    w_cfg;
    owtr_pkg::t_result w_res;

    // The result register can load when empty or when its item leaves now
    assign w_out_free = !r_out_valid || i_m_tready;
    // Step the sequencer on the registered tick when the result can be stored
    assign w_fire     = r_in_valid && w_out_free;
    // The input register takes a new tick when empty or draining this cycle
    assign o_s_tready = !r_in_valid || w_out_free;
    assign w_in_take  = i_s_tvalid && o_s_tready;

    owtr_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    owtr_seq #(
        .TIMER_BITS (TIMER_BITS)
    ) u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_start (r_in_start),
        .i_bus   (r_in_bus),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Input stage: hold the tick until the sequencer consumes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_start <= i_s_tdata[0];
            r_in_bus   <= i_s_tdata[1];
        end
    end

    // Result stage: hold the item while the output side stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {4'b0000, r_out.temperature, r_out.no_device, r_out.done,
                         r_out.busy, r_out.drive_low};

endmodule

FILE: src/owtr_checker.sv
// ----------------------------------------------------------------------------
// owtr_checker
// Port-level checks of the one-wire reader, bound to the top level.
// ----------------------------------------------------------------------------
module owtr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata
);

    // A stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result item changed while stalled");

    // Done only on a busy tick
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[2] |-> o_m_tdata[1])
        else $error("done without busy");

    // No-device flag only with done
    a_nodev_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[3] |-> o_m_tdata[2])
        else $error("no_device without done");

    // The bus is driven only while a sequence runs
    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[0] |-> o_m_tdata[1])
        else $error("bus driven while idle");

endmodule

bind one_wire_temperature_reader_core owtr_checker u_owtr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

FILE: sim/one_wire_temperature_reader_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// one_wire_temperature_reader_core_test
// Self-checking bench for the one-wire temperature reader core. A local
// sequencer model predicts drive, busy, done, no-device and temperature for
// every tick item; a small sensor model answers presence checks and read
// slots so that full measurements run end to end under random stalls.
// ----------------------------------------------------------------------------
module one_wire_temperature_reader_core_test;

    localparam int CLK_PERIOD    = 8;
    localparam int PIPE_LATENCY  = 2;       // result passes the input and result registers
    localparam int TIMER_MAX     = 1023;    // 2^TIMER_BITS - 1
    localparam int RANDOM_TICKS  = 250;
    localparam int MAX_PRINTED   = 20;

    // Sequencer phases of the local model
    typedef enum logic [3:0] {
        SEQ_IDLE, SEQ_RST_LOW, SEQ_RST_WAIT, SEQ_GAP, SEQ_WR_LOW, SEQ_WR_HIGH,
        SEQ_RD_LOW, SEQ_RD_WAIT, SEQ_RD_REC
    } t_seq_phase;

    // Position inside the fixed command sequence
    localparam logic [2:0] STEP_SKIP_FIRST   = 3'd0;
    localparam logic [2:0] STEP_CONVERT      = 3'd1;
    localparam logic [2:0] STEP_SECOND_RESET = 3'd2;
    localparam logic [2:0] STEP_READ_CMD     = 3'd3;
    localparam logic [2:0] STEP_READ_LOW     = 3'd4;
    localparam logic [2:0] STEP_READ_HIGH    = 3'd5;
    localparam logic [2:0] STEP_CLOSE        = 3'd6;

    // Which presence checks the sensor model leaves unanswered
    localparam logic [1:0] FAIL_NONE   = 2'b00;
    localparam logic [1:0] FAIL_FIRST  = 2'b01;
    localparam logic [1:0] FAIL_SECOND = 2'b10;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_s_tvalid  = 1'b0;
    logic                          o_s_tready;
    logic [7:0]                    i_s_tdata   = '0;
    logic                          o_m_tvalid;
    logic                          i_m_tready  = 1'b0;
    logic [23:0]                   o_m_tdata;
    logic                          i_cfg_we    = 1'b0;
    logic [2:0]                    i_cfg_index = '0;
    logic [owtr_pkg::CFG_W-1:0]    i_cfg_wdata = '0;

    one_wire_temperature_reader_core #(
        .TIMER_BITS (10)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Sequencer model state: timing registers and the running sequence
    // ------------------------------------------------------------------
    logic [owtr_pkg::CFG_W-1:0]         seq_cfg [8];
    t_seq_phase                         seq_phase = SEQ_IDLE;
    logic [9:0]                         seq_ticks = '0;
    logic [2:0]                         seq_bits  = '0;
    logic [2:0]                         seq_step  = '0;
    logic [7:0]                         seq_shift = '0;
    logic [7:0]                         seq_low   = '0;
    logic signed [owtr_pkg::TEMP_W-1:0] seq_temp  = '0;

    // Sensor model: word handed out in read slots, presence behavior
    logic [15:0] sensor_word   = '0;
    logic [1:0]  presence_fail = FAIL_NONE;
    bit          bus_noise     = 1'b0;

    // Handshake pressure and bookkeeping
    bit                send_gaps_on   = 1'b1;
    bit                recv_stalls_on = 1'b1;
    int                stall_left     = 0;
    int                ticks_sent     = 0;
    int                outputs_seen   = 0;
    int                mismatches     = 0;
    owtr_pkg::t_result awaited_outputs [$];

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Hold off a runaway or stuck run
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // ------------------------------------------------------------------
    // Model helpers
    // ------------------------------------------------------------------

    // Open the next command byte, read byte or reset once a byte has finished.
    function automatic void enter_step();
        seq_bits = '0;
        case (seq_step)
            STEP_CONVERT: begin
                seq_shift = owtr_pkg::CMD_CONVERT;
                seq_phase = SEQ_WR_LOW;
            end
            STEP_READ_CMD: begin
                seq_shift = owtr_pkg::CMD_READ_SCRATCH;
                seq_phase = SEQ_WR_LOW;
            end
            STEP_READ_LOW, STEP_READ_HIGH: begin
                seq_shift = '0;
                seq_phase = SEQ_RD_LOW;
            end
            STEP_SECOND_RESET: begin
                seq_phase = SEQ_RST_LOW;
            end
            default: begin
                seq_step  = STEP_CLOSE;
                seq_phase = SEQ_RST_LOW;
            end
        endcase
    endfunction

    // Advance the model by one microsecond tick and return the outputs that
    // tick should show. Drive and busy come from the phase at tick start.
    function automatic owtr_pkg::t_result next_bus_outputs(input logic start,
                                                           input logic bus);
        owtr_pkg::t_result          res;
        logic [owtr_pkg::CFG_W-1:0] span;
        logic                       slot_one;
        res           = '0;
        res.drive_low = (seq_phase == SEQ_RST_LOW) || (seq_phase == SEQ_WR_LOW) ||
                        (seq_phase == SEQ_RD_LOW);
        res.busy      = (seq_phase != SEQ_IDLE);
        slot_one      = seq_shift[0];
        if (seq_phase == SEQ_IDLE) begin
            if (start) begin
                seq_phase = SEQ_RST_LOW;
                seq_ticks = '0;
                seq_bits  = '0;
                seq_step  = STEP_SKIP_FIRST;
            end
        end else begin
            case (seq_phase)
                SEQ_RST_LOW:  span = seq_cfg[owtr_pkg::REG_RESET_LOW];
                SEQ_RST_WAIT: span = seq_cfg[owtr_pkg::REG_PRESENCE_WAIT];
                SEQ_GAP:      span = seq_cfg[owtr_pkg::REG_COMMAND_GAP];
                SEQ_WR_LOW:   span = slot_one ? seq_cfg[owtr_pkg::REG_SHORT_SLOT]
                                              : seq_cfg[owtr_pkg::REG_LONG_SLOT];
                SEQ_WR_HIGH:  span = slot_one ? seq_cfg[owtr_pkg::REG_LONG_SLOT]
                                              : seq_cfg[owtr_pkg::REG_SHORT_SLOT];
                SEQ_RD_LOW:   span = seq_cfg[owtr_pkg::REG_READ_LOW];
                SEQ_RD_WAIT:  span = seq_cfg[owtr_pkg::REG_READ_SAMPLE];
                SEQ_RD_REC:   span = seq_cfg[owtr_pkg::REG_READ_RECOVERY];
                default:      span = owtr_pkg::CFG_W'(1);
            endcase
            // a zero-length phase still takes one tick
            if (span == '0) span = owtr_pkg::CFG_W'(1);
            if (({1'b0, seq_ticks} + 11'd1 < {1'b0, span}) && (seq_ticks < TIMER_MAX)) begin
                seq_ticks = seq_ticks + 1'b1;
            end else begin
                seq_ticks = '0;
                case (seq_phase)
                    SEQ_RST_LOW: seq_phase = SEQ_RST_WAIT;
                    SEQ_RST_WAIT: begin
                        // the closing reset ignores the presence sample
                        if (seq_step == STEP_CLOSE) begin
                            seq_phase = SEQ_IDLE;
                            res.done  = 1'b1;
                        end else if (!bus) begin
                            seq_phase = SEQ_GAP;
                        end else begin
                            seq_phase     = SEQ_IDLE;
                            res.done      = 1'b1;
                            res.no_device = 1'b1;
                        end
                    end
                    SEQ_GAP: begin
                        seq_shift = owtr_pkg::CMD_SKIP_ROM;
                        seq_bits  = '0;
                        seq_phase = SEQ_WR_LOW;
                    end
                    SEQ_WR_LOW: seq_phase = SEQ_WR_HIGH;
                    SEQ_WR_HIGH: begin
                        seq_shift = seq_shift >> 1;
                        seq_bits  = seq_bits + 1'b1;
                        if (seq_bits == 0) begin
                            seq_step = seq_step + 1'b1;
                            enter_step();
                        end else begin
                            seq_phase = SEQ_WR_LOW;
                        end
                    end
                    SEQ_RD_LOW: seq_phase = SEQ_RD_WAIT;
                    SEQ_RD_WAIT: begin
                        seq_shift = {bus, seq_shift[7:1]};
                        seq_phase = SEQ_RD_REC;
                    end
                    SEQ_RD_REC: begin
                        seq_bits = seq_bits + 1'b1;
                        if (seq_bits == 0) begin
                            // temperature changes only after the high byte
                            if (seq_step == STEP_READ_LOW) seq_low = seq_shift;
                            else seq_temp = {seq_shift, seq_low};
                            seq_step = seq_step + 1'b1;
                            enter_step();
                        end else begin
                            seq_phase = SEQ_RD_LOW;
                        end
                    end
                    default: seq_phase = SEQ_IDLE;
                endcase
            end
        end
        res.temperature = seq_temp;
        return res;
    endfunction

    // Bus level the sensor shows during the coming tick. Only the last tick
    // of a wait phase is sampled; everything else is noise.
    function automatic logic sensor_level();
        logic lvl;
        case (seq_phase)
            SEQ_RST_WAIT: begin
                if (bus_noise || seq_step == STEP_CLOSE) lvl = 1'($urandom_range(0, 1));
                else if (seq_step == STEP_SKIP_FIRST) lvl = presence_fail[0];
                else lvl = presence_fail[1];
            end
            SEQ_RD_WAIT: lvl = sensor_word[{seq_step == STEP_READ_HIGH, seq_bits}];
            default:     lvl = 1'($urandom_range(0, 1));
        endcase
        return lvl;
    endfunction

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int draw_gap(input bit enabled);
        int r;
        if (!enabled) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Small timing values keep a full measurement to a few hundred ticks.
    function automatic logic [owtr_pkg::CFG_W-1:0] draw_duration(input int floor);
        int r;
        int v;
        r = $urandom_range(0, 99);
        if (r < 35) v = 0;
        else if (r < 85) v = $urandom_range(1, 2);
        else v = $urandom_range(3, 6);
        if (v < floor) v = floor;
        return owtr_pkg::CFG_W'(v);
    endfunction

    // ------------------------------------------------------------------
    // Driving and checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTED) $display("%0t ns: %s", $time, msg);
    endtask

    // Present one tick item, wait for the handshake, then predict it.
    task automatic send_tick(input logic start, input logic bus);
        int gap;
        gap = draw_gap(send_gaps_on);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {6'b0, bus, start};
        do @(posedge i_clk); while (!o_s_tready);
        awaited_outputs.push_back(next_bus_outputs(start, bus));
        ticks_sent++;
    endtask

    // Drop valid and wait until every predicted item has come back.
    task automatic settle_outputs();
        i_s_tvalid <= 1'b0;
        while (awaited_outputs.size() != 0) @(posedge i_clk);
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    // Write all eight timing registers back to back; call only when idle.
    task automatic load_timing(input owtr_pkg::t_cfg timing);
        logic [owtr_pkg::CFG_W-1:0] vals [8];
        vals[owtr_pkg::REG_RESET_LOW]     = timing.reset_low;
        vals[owtr_pkg::REG_PRESENCE_WAIT] = timing.presence_wait;
        vals[owtr_pkg::REG_SHORT_SLOT]    = timing.short_slot;
        vals[owtr_pkg::REG_LONG_SLOT]     = timing.long_slot;
        vals[owtr_pkg::REG_READ_LOW]      = timing.read_low;
        vals[owtr_pkg::REG_READ_SAMPLE]   = timing.read_sample;
        vals[owtr_pkg::REG_READ_RECOVERY] = timing.read_recovery;
        vals[owtr_pkg::REG_COMMAND_GAP]   = timing.command_gap;
        for (int i = 0; i < 8; i++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= 3'(i);
            i_cfg_wdata <= vals[i];
            @(posedge i_clk);
            seq_cfg[i] = vals[i];
        end
        i_cfg_we <= 1'b0;
    endtask

    // Idle a while, request a measurement, and feed ticks until the model
    // is back in idle. Stray start requests while busy must be ignored.
    task automatic run_measurement(input logic [15:0] word, input logic [1:0] fail_mask,
                                   input int idle_ticks);
        sensor_word   = word;
        presence_fail = fail_mask;
        repeat (idle_ticks) send_tick(1'b0, 1'($urandom_range(0, 1)));
        send_tick(1'b1, sensor_level());
        while (seq_phase != SEQ_IDLE) send_tick($urandom_range(0, 9) == 0, sensor_level());
    endtask

    // Random output-side stalls
    always @(posedge i_clk) begin
        int hold;
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else begin
            hold = draw_gap(recv_stalls_on);
            if (hold == 0) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b0;
                stall_left <= hold - 1;
            end
        end
    end

    // Compare each accepted result item with the oldest prediction
    always @(posedge i_clk) begin
        owtr_pkg::t_result got;
        owtr_pkg::t_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = owtr_pkg::t_result'(o_m_tdata[19:0]);
            if (o_m_tdata[23:20] != 0)
                report_mismatch($sformatf("item %0d: padding bits %h not zero",
                                          outputs_seen, o_m_tdata[23:20]));
            if (awaited_outputs.size() == 0) begin
                report_mismatch($sformatf("item %0d: result with no tick pending",
                                          outputs_seen));
            end else begin
                want = awaited_outputs.pop_front();
                if (got.drive_low !== want.drive_low)
                    report_mismatch($sformatf("item %0d: drive_low %b, expected %b",
                                              outputs_seen, got.drive_low, want.drive_low));
                if (got.busy !== want.busy)
                    report_mismatch($sformatf("item %0d: busy %b, expected %b",
                                              outputs_seen, got.busy, want.busy));
                if (got.done !== want.done)
                    report_mismatch($sformatf("item %0d: done %b, expected %b",
                                              outputs_seen, got.done, want.done));
                if (got.no_device !== want.no_device)
                    report_mismatch($sformatf("item %0d: no_device %b, expected %b",
                                              outputs_seen, got.no_device, want.no_device));
                if (got.temperature !== want.temperature)
                    report_mismatch($sformatf("item %0d: temperature %0d, expected %0d",
                                              outputs_seen, got.temperature,
                                              want.temperature));
            end
            outputs_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Power-up reset and presence timing, no register written; the sensor
    // leaves the first presence check unanswered to keep the run short.
    task automatic test_default_timing();
        run_measurement(16'h0191, FAIL_FIRST, 3);
        settle_outputs();
    endtask

    // Shortest legal timing; read back the extreme temperature codes.
    task automatic test_minimum_timing();
        owtr_pkg::t_cfg fast;
        fast          = '0;
        fast.read_low = 10'd1;
        load_timing(fast);
        run_measurement(16'h8000, FAIL_NONE, 0);
        run_measurement(16'h7FFF, FAIL_NONE, 1);
        run_measurement(16'hFFFF, FAIL_NONE, 0);
        run_measurement(16'h0000, FAIL_NONE, 2);
        run_measurement(16'hA5C3, FAIL_NONE, 0);
        settle_outputs();
    endtask

    // Missing presence at either check must keep the old temperature.
    task automatic test_missing_presence();
        run_measurement(16'h1234, FAIL_FIRST, 1);
        run_measurement(16'h1234, FAIL_NONE, 0);
        run_measurement(16'h5A5A, FAIL_SECOND, 2);
        run_measurement(16'hFFFF, FAIL_FIRST | FAIL_SECOND, 0);
        settle_outputs();
    endtask

    // Mostly well-formed measurements with random data, a share of failed
    // presence checks and of noisy presence samples, new timing now and then.
    task automatic test_random_traffic();
        int             stop_at;
        int             r;
        owtr_pkg::t_cfg timing;
        stop_at = ticks_sent + RANDOM_TICKS;
        while (ticks_sent < stop_at) begin
            if ($urandom_range(0, 2) == 0) begin
                settle_outputs();
                timing.reset_low     = draw_duration(0);
                timing.presence_wait = draw_duration(0);
                timing.short_slot    = draw_duration(0);
                timing.long_slot     = draw_duration(0);
                timing.read_low      = draw_duration(1);
                timing.read_sample   = draw_duration(0);
                timing.read_recovery = draw_duration(0);
                timing.command_gap   = draw_duration(0);
                load_timing(timing);
            end
            r         = $urandom_range(0, 99);
            bus_noise = (r >= 90);
            run_measurement(16'($urandom),
                            (r < 70) ? FAIL_NONE : (r < 80) ? FAIL_FIRST : FAIL_SECOND,
                            $urandom_range(0, 4));
        end
        bus_noise = 1'b0;
        settle_outputs();
    endtask

    initial begin
        seq_cfg[owtr_pkg::REG_RESET_LOW]     = owtr_pkg::RST_RESET_LOW;
        seq_cfg[owtr_pkg::REG_PRESENCE_WAIT] = owtr_pkg::RST_PRESENCE_WAIT;
        seq_cfg[owtr_pkg::REG_SHORT_SLOT]    = owtr_pkg::RST_SHORT_SLOT;
        seq_cfg[owtr_pkg::REG_LONG_SLOT]     = owtr_pkg::RST_LONG_SLOT;
        seq_cfg[owtr_pkg::REG_READ_LOW]      = owtr_pkg::RST_READ_LOW;
        seq_cfg[owtr_pkg::REG_READ_SAMPLE]   = owtr_pkg::RST_READ_SAMPLE;
        seq_cfg[owtr_pkg::REG_READ_RECOVERY] = owtr_pkg::RST_READ_RECOVERY;
        seq_cfg[owtr_pkg::REG_COMMAND_GAP]   = owtr_pkg::RST_COMMAND_GAP;

        // Hold reset at the start, then release it for good
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_default_timing();
        test_minimum_timing();
        test_missing_presence();
        test_random_traffic();

        if (mismatches == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
src/owtr_pkg.sv
src/owtr_cfg_regs.sv
src/owtr_seq.sv
src/one_wire_temperature_reader_core.sv
src/owtr_checker.sv
sim/one_wire_temperature_reader_core_test.sv
